FILE: rtl/strb_pkg.sv
package strb_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [5:0] offset_t;
  typedef logic [31:0] word_t;

  localparam kind_t KIND_READ  = 2'd0;
  localparam kind_t KIND_WRITE = 2'd1;
  localparam kind_t KIND_TICK  = 2'd2;
  localparam kind_t KIND_NONE  = 2'd3;

  localparam offset_t OFS_CFG = 6'h00;
  localparam offset_t OFS_CON = 6'h04;
  localparam offset_t OFS_TCB = 6'h08;
  localparam offset_t OFS_TCO = 6'h0C;
  localparam offset_t OFS_TFB = 6'h10;
  localparam offset_t OFS_ICB = 6'h18;
  localparam offset_t OFS_ICO = 6'h1C;
  localparam offset_t OFS_CST = 6'h20;

  localparam int CFG_SWRESET = 16;

  localparam int CON_AUTO   = 5;
  localparam int CON_MANUAL = 4;
  localparam int CON_INTRUN = 3;
  localparam int CON_RUN    = 0;

  localparam int EN_CON    = 10;
  localparam int EN_ICB    = 9;
  localparam int EN_TFB    = 8;
  localparam int EN_TCB    = 7;
  localparam int EN_EXP    = 6;
  localparam int ST_CON    = 5;
  localparam int ST_ICB    = 4;
  localparam int ST_TFB    = 3;
  localparam int ST_TCB    = 2;
  localparam int ST_EXP    = 1;
  localparam int GLOBAL_EN = 0;

  localparam word_t ST_ALL = 32'h0000_003E;

  localparam word_t ICB_RESET = 32'd1;

endpackage

FILE: rtl/system_timer_register_block.sv
// system tick timer register block
//
// request channel: req_valid / req_stall carry kind, offset and write_data.
// a request is a register read, a register write, one elapsed tick period or a no-op.
// response channel: rsp_valid / rsp_stall carry read_data, irq_level and
// bad_offset, one response per request, in request order.
//
// each request is handled in the cycle it is taken; its response is registered
// for the response port. one request per cycle is sustained unless req_stall.
// when the receiver stalls, the response register holds and one more
// response is parked in a skid register; req_stall rises only while that
// skid register is full.
//
// rst (synchronous, active high) restores all register reset values, drops
// the interrupt line and empties both response registers. a configuration
// write with the software-reset bit restores the registers but keeps the
// interrupt line level.
module system_timer_register_block
  import strb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  kind,
  input  logic [5:0]  offset,
  input  logic [31:0] write_data,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] read_data,
  output logic        irq_level,
  output logic        bad_offset
);

  word_t timer_config, timer_config_next;
  word_t timer_control, timer_control_next;
  word_t tick_count_buffer, tick_count_buffer_next;
  word_t tick_fraction_buffer, tick_fraction_buffer_next;
  word_t icb_plus_one, icb_plus_one_next;
  word_t int_counter, int_counter_next;
  word_t int_status, int_status_next;
  logic  irq_line, irq_line_next;

  logic  skid_valid;
  word_t skid_read_data;
  logic  skid_irq;
  logic  skid_bad;

  logic  accept;
  logic  rsp_take;
  word_t rd;
  logic  bad;
  word_t write_plus_one;
  word_t cnt_loaded;
  word_t cnt_dec;
  word_t cst_merged;

  assign accept    = req_valid && !req_stall;
  assign rsp_take  = rsp_valid && !rsp_stall;
  assign req_stall = skid_valid;

  assign write_plus_one = write_data + 32'd1;

  always_comb begin
    timer_config_next         = timer_config;
    timer_control_next        = timer_control;
    tick_count_buffer_next    = tick_count_buffer;
    tick_fraction_buffer_next = tick_fraction_buffer;
    icb_plus_one_next         = icb_plus_one;
    int_counter_next          = int_counter;
    int_status_next           = int_status;
    irq_line_next             = irq_line;
    rd                        = '0;
    bad                       = 1'b0;
    cnt_loaded = (int_counter == '0 && timer_control[CON_AUTO]) ? icb_plus_one : int_counter;
    cnt_dec    = cnt_loaded - 32'd1;
    cst_merged = ((int_status & ST_ALL) | (write_data & ~ST_ALL)) & ~(write_data & ST_ALL);
    if (accept) begin
      unique case (kind)
        KIND_READ: begin
          unique case (offset)
            OFS_CFG: rd = timer_config;
            OFS_CON: rd = timer_control;
            OFS_TCB: rd = tick_count_buffer;
            OFS_TCO: rd = '0;
            OFS_TFB: rd = tick_fraction_buffer;
            OFS_ICB: rd = icb_plus_one - 32'd1;
            OFS_ICO: rd = int_counter;
            OFS_CST: rd = int_status;
            default: bad = 1'b1;
          endcase
        end
        KIND_WRITE: begin
          unique case (offset)
            OFS_CFG: begin
              if (write_data[CFG_SWRESET]) begin
                timer_config_next         = '0;
                timer_control_next        = '0;
                tick_count_buffer_next    = '0;
                tick_fraction_buffer_next = '0;
                icb_plus_one_next         = ICB_RESET;
                int_counter_next          = '0;
                int_status_next           = '0;
              end else begin
                timer_config_next = write_data;
              end
            end
            OFS_CON: begin
              if (int_status[GLOBAL_EN] && int_status[EN_CON]) irq_line_next = 1'b1;
              int_status_next         = int_status;
              int_status_next[ST_CON] = 1'b1;
              timer_control_next      = write_data;
            end
            OFS_TCB: begin
              timer_control_next[CON_RUN] = 1'b0;
              if (int_status[GLOBAL_EN] && int_status[EN_TCB]) irq_line_next = 1'b1;
              int_status_next[ST_TCB] = 1'b1;
              tick_count_buffer_next  = write_data;
            end
            OFS_TFB: begin
              timer_control_next[CON_RUN] = 1'b0;
              if (int_status[GLOBAL_EN] && int_status[EN_TFB]) irq_line_next = 1'b1;
              int_status_next[ST_TFB]   = 1'b1;
              tick_fraction_buffer_next = write_data;
            end
            OFS_ICB: begin
              icb_plus_one_next = write_plus_one;
              if (timer_control[CON_MANUAL]) int_counter_next = write_plus_one;
              if (int_status[GLOBAL_EN] && int_status[EN_ICB]) irq_line_next = 1'b1;
              int_status_next[ST_ICB] = 1'b1;
            end
            OFS_CST: begin
              int_status_next = cst_merged;
              if ((cst_merged & ST_ALL) == '0) irq_line_next = 1'b0;
            end
            default: bad = 1'b1;
          endcase
        end
        KIND_TICK: begin
          if (timer_control[CON_RUN] && timer_control[CON_INTRUN]) begin
            if (cnt_dec == '0 || cnt_dec[31]) begin
              int_counter_next = '0;
              if (int_status[GLOBAL_EN] && int_status[EN_EXP]) irq_line_next = 1'b1;
              int_status_next[ST_EXP] = 1'b1;
            end else begin
              int_counter_next = cnt_dec;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_config         <= '0;
      timer_control        <= '0;
      tick_count_buffer    <= '0;
      tick_fraction_buffer <= '0;
      icb_plus_one         <= ICB_RESET;
      int_counter          <= '0;
      int_status           <= '0;
      irq_line             <= 1'b0;
    end else begin
      timer_config         <= timer_config_next;
      timer_control        <= timer_control_next;
      tick_count_buffer    <= tick_count_buffer_next;
      tick_fraction_buffer <= tick_fraction_buffer_next;
      icb_plus_one         <= icb_plus_one_next;
      int_counter          <= int_counter_next;
      int_status           <= int_status_next;
      irq_line             <= irq_line_next;
    end
  end

  // response register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept && (!rsp_valid || rsp_take)) begin
        rsp_valid  <= 1'b1;
        read_data  <= rd;
        irq_level  <= irq_line_next;
        bad_offset <= bad;
      end else if (accept) begin
        skid_valid     <= 1'b1;
        skid_read_data <= rd;
        skid_irq       <= irq_line_next;
        skid_bad       <= bad;
      end else if (rsp_take) begin
        if (skid_valid) begin
          read_data  <= skid_read_data;
          irq_level  <= skid_irq;
          bad_offset <= skid_bad;
          skid_valid <= 1'b0;
        end else begin
          rsp_valid <= 1'b0;
        end
      end
    end
  end

  a_skid_implies_rsp: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> rsp_valid)
    else $error("skid entry held without a pending response");

  a_irq_rise_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_line) |-> $past(accept && (kind == KIND_WRITE || kind == KIND_TICK)))
    else $error("interrupt line rose without a write or tick");

  a_icb_store: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_WRITE && offset == OFS_ICB) |=>
      (icb_plus_one == $past(write_plus_one)))
    else $error("interrupt count buffer not stored as value plus one");

  a_tick_counter_sign: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_TICK && timer_control[CON_RUN] && timer_control[CON_INTRUN])
      |=> !int_counter[31])
    else $error("running counter left negative after a tick");

endmodule

FILE: tb/system_timer_register_block_tb.sv
module system_timer_register_block_tb
  import strb_pkg::*;
();

  typedef struct packed {
    word_t rdata;
    logic  irq;
    logic  bad;
  } timer_rsp_t;

  class timer_regs_scoreboard;
    word_t cfg;
    word_t con;
    word_t tcb;
    word_t tfb;
    word_t icb_plus_one;
    word_t counter;
    word_t cst;
    logic  line;
    int    errors;
    timer_rsp_t want_responses[$];

    function new();
      restore_regs();
      line = 1'b0;
      errors = 0;
    endfunction

    function void restore_regs();
      cfg = '0;
      con = '0;
      tcb = '0;
      tfb = '0;
      icb_plus_one = ICB_RESET;
      counter = '0;
      cst = '0;
    endfunction

    function void raise_event(int en_bit, int st_bit);
      if (st_bit == ST_TCB || st_bit == ST_TFB) begin
        con[CON_RUN] = 1'b0;
      end
      if (st_bit == ST_ICB && con[CON_MANUAL]) begin
        counter = icb_plus_one;
      end
      if (cst[GLOBAL_EN] && cst[en_bit]) begin
        line = 1'b1;
      end
      cst[st_bit] = 1'b1;
    endfunction

    function void count_down();
      if (!con[CON_RUN] || !con[CON_INTRUN]) begin
        return;
      end
      if (counter == '0 && con[CON_AUTO]) begin
        counter = icb_plus_one;
      end
      counter = counter - 32'd1;
      if (counter == '0 || counter[31]) begin
        counter = '0;
        raise_event(EN_EXP, ST_EXP);
      end
    endfunction

    function void note_request(kind_t k, offset_t o, word_t d);
      timer_rsp_t r;
      r.rdata = '0;
      r.bad = 1'b0;
      case (k)
        KIND_READ: begin
          case (o)
            OFS_CFG: r.rdata = cfg;
            OFS_CON: r.rdata = con;
            OFS_TCB: r.rdata = tcb;
            OFS_TCO: r.rdata = '0;
            OFS_TFB: r.rdata = tfb;
            OFS_ICB: r.rdata = icb_plus_one - 32'd1;
            OFS_ICO: r.rdata = counter;
            OFS_CST: r.rdata = cst;
            default: r.bad = 1'b1;
          endcase
        end
        KIND_WRITE: begin
          case (o)
            OFS_CFG: begin
              if (d[CFG_SWRESET]) begin
                restore_regs();
              end else begin
                cfg = d;
              end
            end
            OFS_CON: begin
              raise_event(EN_CON, ST_CON);
              con = d;
            end
            OFS_TCB: begin
              raise_event(EN_TCB, ST_TCB);
              tcb = d;
            end
            OFS_TFB: begin
              raise_event(EN_TFB, ST_TFB);
              tfb = d;
            end
            OFS_ICB: begin
              icb_plus_one = d + 32'd1;
              raise_event(EN_ICB, ST_ICB);
            end
            OFS_CST: begin
              cst = (cst & ST_ALL) | (d & ~ST_ALL);
              cst &= ~(d & ST_ALL);
              if ((cst & ST_ALL) == '0) begin
                line = 1'b0;
              end
            end
            default: r.bad = 1'b1;
          endcase
        end
        KIND_TICK: count_down();
        default: ;
      endcase
      r.irq = line;
      want_responses.push_back(r);
    endfunction

    function void check_response(word_t rdata, logic irq, logic bad);
      timer_rsp_t w;
      if (want_responses.size() == 0) begin
        $display("%0t unexpected response: read_data %h irq %b bad %b", $time, rdata, irq, bad);
        errors++;
        return;
      end
      w = want_responses.pop_front();
      if (rdata !== w.rdata) begin
        $display("%0t read_data: expected %h, actual %h", $time, w.rdata, rdata);
        errors++;
      end
      if (irq !== w.irq) begin
        $display("%0t irq_level: expected %b, actual %b", $time, w.irq, irq);
        errors++;
      end
      if (bad !== w.bad) begin
        $display("%0t bad_offset: expected %b, actual %b", $time, w.bad, bad);
        errors++;
      end
    endfunction

    function int pending();
      return want_responses.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  kind_t       kind = KIND_READ;
  offset_t     offset = OFS_CFG;
  word_t       write_data = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  word_t       read_data;
  logic        irq_level;
  logic        bad_offset;

  timer_regs_scoreboard regs_sb;
  int burst_left = 0;
  int items_sent = 0;
  int stall_mode = 0;
  int stall_run = 0;

  offset_t reg_offsets[8] = '{OFS_CFG, OFS_CON, OFS_TCB, OFS_TCO,
                              OFS_TFB, OFS_ICB, OFS_ICO, OFS_CST};

  system_timer_register_block dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .kind(kind),
    .offset(offset),
    .write_data(write_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .read_data(read_data),
    .irq_level(irq_level),
    .bad_offset(bad_offset)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stall pattern: free-running, light and heavy stretches
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_run <= $urandom_range(8, 64);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      default: rsp_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      regs_sb.check_response(read_data, irq_level, bad_offset);
    end
  end

  task automatic send_request(kind_t k, offset_t o, word_t d);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    req_valid <= 1'b1;
    kind <= k;
    offset <= o;
    write_data <= d;
    do @(posedge clk); while (req_stall);
    regs_sb.note_request(k, o, d);
    items_sent++;
  endtask

  task automatic run_timer_sequence();
    word_t d;
    d = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      d[GLOBAL_EN] = 1'b1;
    end
    send_request(KIND_WRITE, OFS_CST, d);
    d = $urandom;
    d[CON_RUN] = ($urandom_range(0, 7) != 0);
    d[CON_INTRUN] = ($urandom_range(0, 7) != 0);
    send_request(KIND_WRITE, OFS_CON, d);
    d = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6);
    send_request(KIND_WRITE, OFS_ICB, d);
    repeat ($urandom_range(1, 16)) begin
      case ($urandom_range(0, 5))
        0: send_request(KIND_READ, OFS_ICO, $urandom);
        1: send_request(KIND_READ, OFS_CST, $urandom);
        default: send_request(KIND_TICK, offset_t'($urandom_range(0, 63)), $urandom);
      endcase
    end
    send_request(KIND_WRITE, OFS_CST, $urandom);
  endtask

  initial begin
    word_t   d;
    offset_t o;
    regs_sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_request(KIND_READ, OFS_CFG, '0);
    send_request(KIND_READ, OFS_ICB, '0);
    send_request(KIND_READ, OFS_TCO, '0);
    send_request(KIND_READ, 6'h3F, 32'hFFFF_FFFF);
    send_request(KIND_WRITE, OFS_CST, 32'h0000_07C1);
    send_request(KIND_WRITE, OFS_TCB, 32'hFFFF_FFFF);
    send_request(KIND_WRITE, OFS_TFB, '0);
    send_request(KIND_WRITE, OFS_ICB, 32'hFFFF_FFFF);
    send_request(KIND_WRITE, OFS_ICO, 32'h0000_1234);
    send_request(KIND_WRITE, OFS_TCO, 32'h0000_5678);
    send_request(KIND_WRITE, 6'h14, 32'hA5A5_A5A5);
    send_request(KIND_WRITE, OFS_CON, 32'h0000_0019);
    send_request(KIND_WRITE, OFS_ICB, 32'd2);
    repeat (3) send_request(KIND_TICK, '0, '0);
    send_request(KIND_READ, OFS_ICO, '0);
    send_request(KIND_READ, OFS_CST, '0);
    // clear status, keep enables
    send_request(KIND_WRITE, OFS_CST, ST_ALL | 32'h0000_07C1);
    send_request(KIND_WRITE, OFS_ICB, 32'h8000_0001);
    send_request(KIND_WRITE, OFS_CON, 32'h0000_0029);
    send_request(KIND_TICK, 6'h3F, 32'hFFFF_FFFF);
    send_request(KIND_NONE, OFS_CST, 32'hFFFF_FFFF);
    // software reset keeps the line up
    send_request(KIND_WRITE, OFS_CFG, 32'h0001_0000);
    send_request(KIND_READ, OFS_CST, '0);
    send_request(KIND_WRITE, OFS_CFG, 32'hFFFE_FFFF);
    send_request(KIND_READ, OFS_CFG, '0);

    while (items_sent < 1725) begin
      case ($urandom_range(0, 9))
        0, 1: send_request(kind_t'($urandom_range(0, 3)), offset_t'($urandom_range(0, 63)),
                           $urandom);
        2, 3: begin
          o = reg_offsets[$urandom_range(0, 7)];
          d = $urandom;
          if (o == OFS_CFG && $urandom_range(0, 7) != 0) begin
            d[CFG_SWRESET] = 1'b0;
          end
          send_request($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, o, d);
        end
        default: run_timer_sequence();
      endcase
    end

    req_valid <= 1'b0;
    while (regs_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (regs_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
